// ===== hdl/free_run_bitmap_finder_assert.svh =====
// Assertion macros for the free run bitmap finder.
// Used by the top level only; expands to nothing when SYNTHESIS is defined.
`ifndef FREE_RUN_BITMAP_FINDER_ASSERT_SVH
`define FREE_RUN_BITMAP_FINDER_ASSERT_SVH
`ifndef SYNTHESIS
// Whenever the antecedent holds, the consequent holds in the same cycle.
`define FBF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("free_run_bitmap_finder: same-cycle check failed");
// Whenever the antecedent holds, the consequent holds in the next cycle.
`define FBF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("free_run_bitmap_finder: next-cycle check failed");
`else
`define FBF_ASSERT_SAME(label, ante, cons)
`define FBF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/fbf_pkg.sv =====
// Shared constants and types of the free run bitmap finder.
// No dependencies; every other file but the assertion header refers to it by scoped names.
`default_nettype none

package fbf_pkg;

  // Width of a cluster number; counting wraps at this width.
  localparam int CLUSTER_BITS = 48;
  localparam int LENGTH_BITS  = 32;
  localparam int CFG_DATA_W   = 48;
  localparam int CFG_INDEX_W  = 2;

  // Eight lanes for the bits of one byte, one more for the end of the bitmap.
  localparam int LANES      = 8;
  localparam int LANE_IDX_W = 4;
  localparam int LANE_OFS_W = 3;

  localparam logic [LENGTH_BITS-1:0] MIN_LENGTH_RESET = LENGTH_BITS'(32);

  typedef logic [CLUSTER_BITS-1:0] cluster_t;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_START_CLUSTER = 2'd0,
    REG_MIN_CLUSTER   = 2'd1,
    REG_MIN_LENGTH    = 2'd2,
    REG_CLUSTER_LIMIT = 2'd3
  } cfg_index_t;

  // What one lane reports for its cluster after the lane register.
  typedef struct packed {
    logic     hit_limit;
    logic     hit_run;
    cluster_t run_begin;
    cluster_t run_end;
  } lane_t;

  // Merged outcome of one byte.
  typedef struct packed {
    logic     valid;
    logic     found;
    cluster_t run_begin;
    cluster_t run_end;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/fbf_ifs.sv =====
// Valid/ready channel interfaces of the free run bitmap finder.
// Depends on fbf_pkg for the cluster width.
`default_nettype none

// Bitmap input channel: one byte of cluster flags per beat.
interface fbf_bitmap_if;
  logic       valid;
  logic       ready;
  logic [7:0] bitmap_byte;
  logic       last_byte;

  modport source (output valid, output bitmap_byte, output last_byte, input ready);
  modport sink (input valid, input bitmap_byte, input last_byte, output ready);
endinterface

// Result channel: one beat per finished search.
interface fbf_result_if;
  logic                  valid;
  logic                  ready;
  logic                  found;
  fbf_pkg::cluster_t     run_begin;
  fbf_pkg::cluster_t     run_end;

  modport source (output valid, output found, output run_begin, output run_end, input ready);
  modport sink (input valid, input found, input run_begin, input run_end, output ready);
endinterface

`default_nettype wire

// ===== hdl/free_run_bitmap_finder.sv =====
// Free run bitmap finder. Takes an allocation bitmap one byte per beat, bit 0
// first, a set bit meaning the cluster is in use, and reports the first free
// run that begins at or above min_cluster and spans at least min_length
// clusters, or a not-found beat when the limit is reached or the last byte
// passes without a match. One bitmap byte is accepted every cycle unless a
// waiting result holds the stages; the byte that decides a result passes
// through the snapshot register, lane register and output register. Eight
// lanes check the bits of a byte side by side and a ninth closes an open run
// on the last byte. After a result, further bytes are taken and dropped until
// start_cluster is written, which starts a new search.
// Depends on fbf_pkg, fbf_ifs, fbf_lane, fbf_merge and the assertion header.
`default_nettype none
`include "free_run_bitmap_finder_assert.svh"

module free_run_bitmap_finder (
  input  wire logic                                clk,
  input  wire logic                                rst,
  fbf_bitmap_if.sink                               bitmap,
  fbf_result_if.source                             result,
  input  wire logic                                cfg_we,
  input  wire logic [fbf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [fbf_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Configuration registers.
  fbf_pkg::cluster_t                     start_cluster;
  fbf_pkg::cluster_t                     min_cluster;
  logic [fbf_pkg::LENGTH_BITS-1:0]       min_length;
  fbf_pkg::cluster_t                     cluster_limit;

  // Search state as of the next byte.
  fbf_pkg::cluster_t                     cur;
  logic                                  prev_used;
  fbf_pkg::cluster_t                     run_start;
  fbf_pkg::cluster_t                     run_start_next;
  logic                                  done;

  // Snapshot stage.
  logic                                  s1_v;
  logic [7:0]                            s1_byte;
  logic                                  s1_last;
  fbf_pkg::cluster_t                     s1_cur;
  logic                                  s1_prev;
  fbf_pkg::cluster_t                     s1_run_start;

  // Lane stage.
  logic                                  s2_v;
  logic                                  s2_last;

  // Output register.
  logic                                  out_v;
  logic                                  out_found;
  fbf_pkg::cluster_t                     out_begin;
  fbf_pkg::cluster_t                     out_end;

  logic                                  in_beat;
  logic                                  out_free;
  logic                                  s2_adv;
  logic                                  s1_adv;
  logic                                  start_write;
  logic                                  take_result;
  logic [fbf_pkg::LANES:0]               in_flags;
  logic [fbf_pkg::LANES:0]               s1_flags;
  fbf_pkg::lane_t [fbf_pkg::LANES:0]     lanes;
  fbf_pkg::result_t                      merged;

  // Handshake and stage advance; a stage moves when the next one is free.
  always_comb begin
    out_free     = !out_v || result.ready;
    s2_adv       = s2_v && out_free;
    s1_adv       = s1_v && (!s2_v || s2_adv);
    bitmap.ready = !s1_v || s1_adv;
    in_beat      = bitmap.valid && bitmap.ready;
    start_write  = cfg_we && (cfg_index == fbf_pkg::REG_START_CLUSTER);
    take_result  = s2_adv && merged.valid && !done;
  end

  // Flags of the incoming byte, with the used flag of the cluster before it.
  assign in_flags = {bitmap.bitmap_byte, prev_used};

  // Start of the last run opened within the incoming byte, if any.
  always_comb begin
    run_start_next = run_start;
    for (int j = 0; j < fbf_pkg::LANES; j++) begin
      if (in_flags[j] && !in_flags[j+1]) begin
        run_start_next = cur + fbf_pkg::CLUSTER_BITS'(j);
      end
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_cluster <= '0;
      min_cluster   <= '0;
      min_length    <= fbf_pkg::MIN_LENGTH_RESET;
      cluster_limit <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fbf_pkg::REG_START_CLUSTER: start_cluster <= cfg_data;
        fbf_pkg::REG_MIN_CLUSTER:   min_cluster   <= cfg_data;
        fbf_pkg::REG_MIN_LENGTH:    min_length    <= cfg_data[fbf_pkg::LENGTH_BITS-1:0];
        fbf_pkg::REG_CLUSTER_LIMIT: cluster_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Search state: advanced on every accepted byte, restarted by a start write.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur       <= '0;
      prev_used <= 1'b1;
      run_start <= '0;
      done      <= 1'b0;
    end else if (start_write) begin
      cur       <= cfg_data;
      prev_used <= 1'b1;
      run_start <= '0;
      done      <= 1'b0;
    end else begin
      if (in_beat) begin
        cur       <= cur + fbf_pkg::CLUSTER_BITS'(fbf_pkg::LANES);
        prev_used <= bitmap.bitmap_byte[fbf_pkg::LANES-1];
        run_start <= run_start_next;
      end
      if (take_result) begin
        done <= 1'b1;
      end
    end
  end

  // Snapshot stage valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (in_beat) begin
      s1_v <= 1'b1;
    end else if (s1_adv) begin
      s1_v <= 1'b0;
    end
  end

  // Snapshot payload: the byte with the state it starts from.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_byte      <= bitmap.bitmap_byte;
      s1_last      <= bitmap.last_byte;
      s1_cur       <= cur;
      s1_prev      <= prev_used;
      s1_run_start <= run_start;
    end
  end

  // Lane stage valid bit and the last-byte flag that travels with it.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s1_adv) begin
      s2_v <= 1'b1;
    end else if (s2_adv) begin
      s2_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_last <= s1_last;
    end
  end

  assign s1_flags = {s1_byte, s1_prev};

  // Nine lanes: one per bit, and one that closes a run on the last byte.
  for (genvar g = 0; g <= fbf_pkg::LANES; g++) begin : g_lane
    // Flag of this lane's own cluster; the closing lane does not use it.
    localparam int CLOSE_IDX = (g < fbf_pkg::LANES) ? g + 1 : 0;

    fbf_lane u_lane (
      .clk           (clk),
      .load          (s1_adv),
      .idx           (fbf_pkg::LANE_IDX_W'(g)),
      .flags         (s1_flags),
      .closing       ((g == fbf_pkg::LANES) ? s1_last : s1_flags[CLOSE_IDX]),
      .limit_en      (g != fbf_pkg::LANES),
      .cur           (s1_cur),
      .run_start     (s1_run_start),
      .min_cluster   (min_cluster),
      .min_length    (min_length),
      .cluster_limit (cluster_limit),
      .lane          (lanes[g])
    );
  end

  fbf_merge u_merge (
    .lanes  (lanes),
    .last   (s2_last),
    .result (merged)
  );

  // Output register; holds a beat until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (take_result) begin
      out_v <= 1'b1;
    end else if (result.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_result) begin
      out_found <= merged.found;
      out_begin <= merged.run_begin;
      out_end   <= merged.run_end;
    end
  end

  assign result.valid     = out_v;
  assign result.found     = out_found;
  assign result.run_begin = out_begin;
  assign result.run_end   = out_end;

  // A search only reopens through a start_cluster write.
  `FBF_ASSERT_SAME(a_done_reopen, $fell(done), $past(start_write))
  // A new result never comes out of a search that already gave one.
  `FBF_ASSERT_SAME(a_single_result, $rose(out_v), !$past(done))
  // A lane beat blocked by a waiting result stays in the lane stage.
  `FBF_ASSERT_NEXT(a_lane_hold, s2_v && !out_free, s2_v)

endmodule

`default_nettype wire

// ===== hdl/fbf_lane.sv =====
// One lane of the finder: checks a single cluster position of a byte.
// Depends on fbf_pkg; instantiated nine times by the top level.
`default_nettype none

module fbf_lane (
  input  wire logic                               clk,
  input  wire logic                               load,
  input  wire logic [fbf_pkg::LANE_IDX_W-1:0]     idx,
  input  wire logic [fbf_pkg::LANES:0]            flags,
  input  wire logic                               closing,
  input  wire logic                               limit_en,
  input  wire fbf_pkg::cluster_t                  cur,
  input  wire fbf_pkg::cluster_t                  run_start,
  input  wire fbf_pkg::cluster_t                  min_cluster,
  input  wire logic [fbf_pkg::LENGTH_BITS-1:0]    min_length,
  input  wire fbf_pkg::cluster_t                  cluster_limit,
  output fbf_pkg::lane_t                          lane
);

  logic                              open_any;
  logic [fbf_pkg::LANE_OFS_W-1:0]    open_ofs;
  fbf_pkg::cluster_t                 here;
  fbf_pkg::cluster_t                 begin_c;
  logic                              ends_run;
  logic                              at_limit;

  // Registered lane state.
  logic                              ends;
  logic                              limit;
  fbf_pkg::cluster_t                 begin_q;
  fbf_pkg::cluster_t                 here_q;

  fbf_pkg::cluster_t                 run_len;
  logic                              qualifies;

  // Find the latest run opened below this lane: a used flag followed by a free one.
  always_comb begin
    open_any = 1'b0;
    open_ofs = '0;
    for (int j = 0; j < fbf_pkg::LANES; j++) begin
      if (j < int'(idx) && flags[j] && !flags[j+1]) begin
        open_any = 1'b1;
        open_ofs = fbf_pkg::LANE_OFS_W'(j);
      end
    end
  end

  // Cluster of this lane, the start of the run it would close, and the limit check.
  always_comb begin
    here     = cur + fbf_pkg::CLUSTER_BITS'(idx);
    begin_c  = open_any ? (cur + fbf_pkg::CLUSTER_BITS'(open_ofs)) : run_start;
    ends_run = !flags[idx] && closing;
    at_limit = limit_en && (cluster_limit != '0) && (here >= cluster_limit);
  end

  // Lane register; the valid bit lives in the top level.
  always_ff @(posedge clk) begin
    if (load) begin
      ends    <= ends_run;
      limit   <= at_limit;
      begin_q <= begin_c;
      here_q  <= here;
    end
  end

  // Length and position checks of the closed run.
  always_comb begin
    run_len   = here_q - begin_q;
    qualifies = (begin_q >= min_cluster) &&
                (run_len >= fbf_pkg::CLUSTER_BITS'(min_length));
    lane.hit_limit = limit;
    lane.hit_run   = ends && qualifies;
    lane.run_begin = begin_q;
    lane.run_end   = here_q;
  end

endmodule

`default_nettype wire

// ===== hdl/fbf_merge.sv =====
// Merging stage: picks the lowest lane that ends the search.
// Depends on fbf_pkg; fed by the nine fbf_lane instances.
`default_nettype none

module fbf_merge (
  input  wire fbf_pkg::lane_t [fbf_pkg::LANES:0] lanes,
  input  wire logic                              last,
  output fbf_pkg::result_t                       result
);

  // Walk from the highest lane down so that the lowest hit wins. Within a
  // lane the limit check comes before the run check.
  always_comb begin
    result.valid     = last;
    result.found     = 1'b0;
    result.run_begin = '0;
    result.run_end   = '0;
    for (int i = fbf_pkg::LANES; i >= 0; i--) begin
      if (lanes[i].hit_limit) begin
        result.valid     = 1'b1;
        result.found     = 1'b0;
        result.run_begin = '0;
        result.run_end   = '0;
      end else if (lanes[i].hit_run) begin
        result.valid     = 1'b1;
        result.found     = 1'b1;
        result.run_begin = lanes[i].run_begin;
        result.run_end   = lanes[i].run_end;
      end
    end
  end

endmodule

`default_nettype wire
